// ----- rtl/tmtd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trimmed-mean detector package
// Shared constants, payload types and small helpers for the detector blocks.
// ----------------------------------------------------------------------------
package tmtd_pkg;

  // Window shape and sample width
  localparam int WINDOW_SAMPLES = 14;
  localparam int TRIM_LOW       = 2;
  localparam int TRIM_HIGH      = 2;
  localparam int SAMPLE_BITS    = 12;

  // Fixed port field widths
  localparam int FIELD_BITS    = 12;
  localparam int MEAN_BITS     = 12;
  localparam int THRESH_BITS   = 12;
  localparam int HOLDOFF_BITS  = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_IDX_BITS  = 1;

  // Derived sizes
  localparam int LOW_SLOTS  = (TRIM_LOW > 0) ? TRIM_LOW : 1;
  localparam int HIGH_SLOTS = (TRIM_HIGH > 0) ? TRIM_HIGH : 1;
  localparam int SUM_BITS   = $clog2(WINDOW_SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int CNT_BITS   = $clog2(WINDOW_SAMPLES);
  localparam int PROD_BITS  = 2 * SUM_BITS + 1;
  localparam int KEEP_COUNT = WINDOW_SAMPLES - TRIM_LOW - TRIM_HIGH;
  localparam int DIVISOR    = (KEEP_COUNT < 1) ? 1 : KEEP_COUNT;

  // Reciprocal of the divisor, scaled by 2^SUM_BITS; the estimate it gives is
  // at most one below the true quotient.
  localparam logic [SUM_BITS:0]   RECIP = (SUM_BITS + 1)'((1 << SUM_BITS) / DIVISOR);
  localparam logic [SUM_BITS-1:0] DIV_C = SUM_BITS'(DIVISOR);

  // Queue sizes
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);
  localparam int QCNT_BITS  = QPTR_BITS + 1;

  // Reset values
  localparam logic [SAMPLE_BITS-1:0]  SAMPLE_ONES   = '1;
  localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_MAX   = '1;
  localparam logic [HOLDOFF_BITS-1:0] HOLDOFF_RESET = 16'd500;
  localparam logic [THRESH_BITS-1:0]  THRESH_RESET  = '0;

  // Item kind; in the command queue OP_SAMPLE marks a window close
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DETECT_THRESHOLD = 1'b0,
    CFG_REPORT_HOLDOFF   = 1'b1
  } cfg_idx_e;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SUM_BITS-1:0]    sum_t;

  typedef struct packed {
    op_e                   operation;
    logic [FIELD_BITS-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_BITS-1:0] trimmed_mean;
    logic                 report;
  } out_item_t;

  typedef struct packed {
    op_e                           kind;
    sum_t                          sum;
    sample_t [LOW_SLOTS-1:0]       lows;
    sample_t [HIGH_SLOTS-1:0]      highs;
  } cmd_t;

  typedef struct packed {
    logic [THRESH_BITS-1:0]  detect_threshold;
    logic [HOLDOFF_BITS-1:0] report_holdoff;
  } cfg_t;

  // Fit the input field to the sample width
  function automatic sample_t to_sample(logic [FIELD_BITS-1:0] raw);
    logic [SAMPLE_BITS+FIELD_BITS-1:0] wide;
    wide = {{SAMPLE_BITS{1'b0}}, raw};
    return wide[SAMPLE_BITS-1:0];
  endfunction

  // Keep the low bits of the mean for the output field
  function automatic logic [MEAN_BITS-1:0] mean_field(sum_t q);
    logic [SUM_BITS+MEAN_BITS-1:0] wide;
    wide = {{MEAN_BITS{1'b0}}, q};
    return wide[MEAN_BITS-1:0];
  endfunction

  // Strict compare of the full mean against the threshold
  function automatic logic above_threshold(sum_t q, logic [THRESH_BITS-1:0] thr);
    logic [SUM_BITS+THRESH_BITS-1:0] wq;
    logic [SUM_BITS+THRESH_BITS-1:0] wt;
    wq = {{THRESH_BITS{1'b0}}, q};
    wt = {{SUM_BITS{1'b0}}, thr};
    return wq > wt;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/trimmed_mean_threshold_detector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Trimmed-mean threshold detector
// Windowed trimmed mean of sensor samples with a thresholded, held-off report.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock while full is low: a sample or
// a millisecond tick. Every 14th sample closes a window and yields one
// result, the mean of the window without its two smallest and two largest
// values and a report flag; ticks and other samples yield nothing. A result
// reaches the result port through the command queue register, the
// three-stage trim/divide pipeline in the back end and the result queue.
// Ticks and window closes each take one slot of a four-entry command queue
// that the back end drains at one entry per cycle, so full only rises while
// the back end is held by a full four-entry result queue. Write the two
// configuration registers only while no result is pending.
// ----------------------------------------------------------------------------
module trimmed_mean_threshold_detector (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  output      logic                                 full,
  input  wire tmtd_pkg::in_item_t                   in_item_i,
  output      logic                                 empty,
  input  wire logic                                 pop,
  output      tmtd_pkg::out_item_t                  out_item_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tmtd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [tmtd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import tmtd_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;
  cmd_t cmd_out;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DETECT_THRESHOLD: cfg_d.detect_threshold = cfg_data_i[THRESH_BITS-1:0];
        CFG_REPORT_HOLDOFF:   cfg_d.report_holdoff   = cfg_data_i[HOLDOFF_BITS-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.detect_threshold <= THRESH_RESET;
      cfg_q.report_holdoff   <= HOLDOFF_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full = cmd_full;

  tmtd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (push),
    .in_item_i  (in_item_i),
    .cmd_full_i (cmd_full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  tmtd_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .data_o  (cmd_out)
  );

  tmtd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd_out),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .out_pop_i   (pop),
    .out_empty_o (empty),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ----- rtl/tmtd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector front end
// Accepts samples and ticks, tracks the window sum and extremes, and queues
// ticks and window closes for the back end.
// ----------------------------------------------------------------------------
module tmtd_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire tmtd_pkg::in_item_t  in_item_i,
  input  wire logic                cmd_full_i,
  output      logic                cmd_push_o,
  output      tmtd_pkg::cmd_t      cmd_o
);
  import tmtd_pkg::*;

  logic                     accept;
  logic                     is_sample;
  logic                     closing;
  sample_t                  v;
  sum_t                     sum_new;
  sample_t [LOW_SLOTS-1:0]  lows_new;
  sample_t [HIGH_SLOTS-1:0] highs_new;

  logic [CNT_BITS-1:0]      count_q, count_d;
  sum_t                     sum_q, sum_d;
  sample_t [LOW_SLOTS-1:0]  lows_q, lows_d;
  sample_t [HIGH_SLOTS-1:0] highs_q, highs_d;

  assign accept    = in_valid_i && !cmd_full_i;
  assign is_sample = accept && (in_item_i.operation == OP_SAMPLE);
  assign closing   = (count_q == CNT_BITS'(WINDOW_SAMPLES - 1));
  assign v         = to_sample(in_item_i.sample_value);
  assign sum_new   = sum_q + sum_t'(v);

  // Insert into the ascending list of smallest values; ties do not displace
  always_comb begin
    logic    prev_lt;
    sample_t prev_val;
    logic    cur_lt;
    lows_new = lows_q;
    prev_lt  = 1'b0;
    prev_val = v;
    for (int j = 0; j < TRIM_LOW; j++) begin
      cur_lt = v < lows_q[j];
      if (cur_lt) begin
        lows_new[j] = prev_lt ? prev_val : v;
      end
      prev_lt  = cur_lt;
      prev_val = lows_q[j];
    end
  end

  // Insert into the descending list of largest values; ties do not displace
  always_comb begin
    logic    prev_gt;
    sample_t prev_val;
    logic    cur_gt;
    highs_new = highs_q;
    prev_gt   = 1'b0;
    prev_val  = v;
    for (int j = 0; j < TRIM_HIGH; j++) begin
      cur_gt = v > highs_q[j];
      if (cur_gt) begin
        highs_new[j] = prev_gt ? prev_val : v;
      end
      prev_gt  = cur_gt;
      prev_val = highs_q[j];
    end
  end

  // Advance the window, or restart it on close
  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    lows_d  = lows_q;
    highs_d = highs_q;
    if (is_sample) begin
      if (closing) begin
        count_d = '0;
        sum_d   = '0;
        lows_d  = {LOW_SLOTS{SAMPLE_ONES}};
        highs_d = '0;
      end else begin
        count_d = count_q + CNT_BITS'(1);
        sum_d   = sum_new;
        lows_d  = lows_new;
        highs_d = highs_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      lows_q  <= {LOW_SLOTS{SAMPLE_ONES}};
      highs_q <= '0;
    end else begin
      count_q <= count_d;
      sum_q   <= sum_d;
      lows_q  <= lows_d;
      highs_q <= highs_d;
    end
  end

  // Queue ticks and window closes in arrival order
  assign cmd_push_o  = accept && ((in_item_i.operation == OP_TICK) || closing);
  assign cmd_o.kind  = in_item_i.operation;
  assign cmd_o.sum   = sum_new;
  assign cmd_o.lows  = lows_new;
  assign cmd_o.highs = highs_new;

endmodule
`default_nettype wire

// ----- rtl/tmtd_cmd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector command queue
// Short queue of ticks and window closes between the front and back ends.
// ----------------------------------------------------------------------------
module tmtd_cmd_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire tmtd_pkg::cmd_t  data_i,
  output      logic            full_o,
  input  wire logic            pop_i,
  output      logic            empty_o,
  output      tmtd_pkg::cmd_t  data_o
);
  import tmtd_pkg::*;

  cmd_t                 mem_q [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 do_push;
  logic                 do_pop;

  assign full_o  = (count_q == QCNT_BITS'(QDEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + QPTR_BITS'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + QPTR_BITS'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + QCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the entry
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tmtd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector back end
// Trims and divides closed windows, runs the hold-off counter, decides the
// report flag and queues results.
// ----------------------------------------------------------------------------
module tmtd_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tmtd_pkg::cfg_t      cfg_i,
  input  wire tmtd_pkg::cmd_t      cmd_i,
  input  wire logic                cmd_empty_i,
  output      logic                cmd_pop_o,
  input  wire logic                out_pop_i,
  output      logic                out_empty_o,
  output      tmtd_pkg::out_item_t out_item_o
);
  import tmtd_pkg::*;

  logic                    en;
  sum_t                    reduced;
  logic [PROD_BITS-1:0]    prod;
  sum_t                    q_times_d;
  sum_t                    rem;
  sum_t                    q_fixed;
  logic                    commit;
  logic                    rep;
  logic                    out_push;
  logic                    out_pop;
  logic                    out_full;

  // Pipeline: reduce, estimate quotient, correct quotient
  logic                    s1_v_q;
  op_e                     s1_kind_q;
  sum_t                    s1_red_q;
  logic                    s2_v_q;
  op_e                     s2_kind_q;
  sum_t                    s2_x_q;
  sum_t                    s2_q_q;
  logic                    s3_v_q;
  op_e                     s3_kind_q;
  sum_t                    s3_q_q;

  logic [HOLDOFF_BITS-1:0] holdoff_q, holdoff_d;

  out_item_t               out_mem_q [QDEPTH];
  out_item_t               out_new;
  logic [QPTR_BITS-1:0]    out_wr_q, out_wr_d;
  logic [QPTR_BITS-1:0]    out_rd_q, out_rd_d;
  logic [QCNT_BITS-1:0]    out_cnt_q, out_cnt_d;

  // Hold the whole pipeline when a result cannot enter the result queue
  assign en        = !(s3_v_q && (s3_kind_q == OP_SAMPLE) && out_full);
  assign cmd_pop_o = en && !cmd_empty_i;

  // Drop the extremes from the sum, saturating at zero
  always_comb begin
    reduced = cmd_i.sum;
    for (int i = 0; i < TRIM_LOW; i++) begin
      reduced = (reduced > sum_t'(cmd_i.lows[i])) ? reduced - sum_t'(cmd_i.lows[i]) : '0;
    end
    for (int i = 0; i < TRIM_HIGH; i++) begin
      reduced = (reduced > sum_t'(cmd_i.highs[i])) ? reduced - sum_t'(cmd_i.highs[i]) : '0;
    end
  end

  // Reciprocal multiply, then one correction step
  assign prod      = PROD_BITS'(s1_red_q) * PROD_BITS'(RECIP);
  assign q_times_d = sum_t'(s2_q_q * DIV_C);
  assign rem       = s2_x_q - q_times_d;
  assign q_fixed   = (rem >= DIV_C) ? s2_q_q + sum_t'(1) : s2_q_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= !cmd_empty_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_kind_q <= cmd_i.kind;
      s1_red_q  <= reduced;
      s2_kind_q <= s1_kind_q;
      s2_x_q    <= s1_red_q;
      s2_q_q    <= prod[2*SUM_BITS-1:SUM_BITS];
      s3_kind_q <= s2_kind_q;
      s3_q_q    <= q_fixed;
    end
  end

  // Decide the report and run the hold-off counter in item order
  assign commit  = en && s3_v_q;
  assign rep     = above_threshold(s3_q_q, cfg_i.detect_threshold) &&
                   (holdoff_q >= cfg_i.report_holdoff);
  assign out_push = commit && (s3_kind_q == OP_SAMPLE);
  assign out_new.trimmed_mean = mean_field(s3_q_q);
  assign out_new.report       = rep;

  always_comb begin
    holdoff_d = holdoff_q;
    if (commit) begin
      case (s3_kind_q)
        OP_TICK: begin
          if (holdoff_q != HOLDOFF_MAX) begin
            holdoff_d = holdoff_q + HOLDOFF_BITS'(1);
          end
        end
        OP_SAMPLE: begin
          if (rep) begin
            holdoff_d = '0;
          end
        end
        default: holdoff_d = holdoff_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q <= HOLDOFF_MAX;
    end else begin
      holdoff_q <= holdoff_d;
    end
  end

  // Result queue
  assign out_full    = (out_cnt_q == QCNT_BITS'(QDEPTH));
  assign out_empty_o = (out_cnt_q == '0);
  assign out_pop     = out_pop_i && !out_empty_o;
  assign out_item_o  = out_mem_q[out_rd_q];

  always_comb begin
    out_wr_d  = out_push ? out_wr_q + QPTR_BITS'(1) : out_wr_q;
    out_rd_d  = out_pop  ? out_rd_q + QPTR_BITS'(1) : out_rd_q;
    out_cnt_d = out_cnt_q;
    if (out_push && !out_pop) begin
      out_cnt_d = out_cnt_q + QCNT_BITS'(1);
    end else if (out_pop && !out_push) begin
      out_cnt_d = out_cnt_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_wr_q  <= '0;
      out_rd_q  <= '0;
      out_cnt_q <= '0;
    end else begin
      out_wr_q  <= out_wr_d;
      out_rd_q  <= out_rd_d;
      out_cnt_q <= out_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_push) begin
      out_mem_q[out_wr_q] <= out_new;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tmtd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Detector port checker
// Watches the detector's ports and flags queue and report misbehavior.
// ----------------------------------------------------------------------------
module tmtd_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 push,
  input  wire logic                                 full,
  input  wire logic                                 empty,
  input  wire logic                                 pop,
  input  wire tmtd_pkg::out_item_t                  out_item_o,
  input  wire logic                                 cfg_we_i,
  input  wire logic [tmtd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire logic [tmtd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import tmtd_pkg::*;

  logic [THRESH_BITS-1:0] thr_q;

  // Track the threshold as written through the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_DETECT_THRESHOLD)) begin
      thr_q <= cfg_data_i[THRESH_BITS-1:0];
    end
  end

  // The result queue comes out of reset empty and the command queue not full
  a_reset_queues: assert property (@(posedge clk_i)
    !rst_ni |=> (empty && !full))
    else $error("queues not cleared by reset");

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("waiting result changed or vanished");

  // A report only comes with a mean above the threshold
  a_report_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.report) |-> (out_item_o.trimmed_mean > thr_q))
    else $error("report with mean at or below threshold");

  // The input side only fills up after a transaction enters
  a_full_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted transaction");

endmodule

bind trimmed_mean_threshold_detector tmtd_checker u_tmtd_checker (.*);
`default_nettype wire
